>>> rtl/ray_plane_intersection_assert.svh
// Assertion macros used by the checker file of the line and plane intersection block.
`ifndef RAY_PLANE_INTERSECTION_ASSERT_SVH
`define RAY_PLANE_INTERSECTION_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define RPI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define RPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rpi_pkg.sv
// Package with the types, constants and status codes of the intersection block.
`default_nettype none
package rpi_pkg;

  // Coordinate format is fixed by the beat layout.
  localparam int COORD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int STATUS_W      = 2;

  // Widest operand slice fed to one multiplier stage.
  localparam int MUL_CHUNK = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [STATUS_W-1:0]       status_t;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_PARALLEL = 2'd1;
  localparam status_t STATUS_SAT      = 2'd2;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    coord_t plane_a;
    coord_t plane_b;
    coord_t plane_c;
    coord_t plane_offset;
  } ray_in_t;

  typedef struct packed {
    coord_t  hit_x;
    coord_t  hit_y;
    coord_t  hit_z;
    status_t status;
  } hit_out_t;

endpackage
`default_nettype wire

>>> rtl/ray_plane_intersection.sv
// Top level of the pipelined line and plane intersection block.
//
//  Channel | Direction | Handshake           | Beat
//  in_     | input     | in_valid, in_stall   | ray_in_t: two line points, plane terms
//  out_    | output    | out_valid, out_stall | hit_out_t: point and status
//
// One beat is accepted per cycle while in_stall is low. Coordinates are Q16.16 in 32 bits
// by default, and each coordinate has its own bit-per-stage divider. Reset is synchronous
// and active low and clears only valid bits and the queue pointers, count and ready flag.
// The whole pipeline holds while the two-entry result queue is full; in_stall is a
// registered signal.
`default_nettype none
module ray_plane_intersection import rpi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ray_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hit_out_t out_data
);

  localparam int W    = COORD_W;
  localparam int VW   = W + 1;
  localparam int SPW  = 2 * W;
  localparam int DPW  = W + VW;
  localparam int NW   = ((2 * W > W + FRAC_BITS) ? 2 * W : W + FRAC_BITS) + 2;
  localparam int DW   = DPW + 2;
  localparam int NUMW = NW + VW;
  localparam int QW   = W + 2;
  localparam int DAW  = NUMW + 1;
  localparam int DBW  = DW + 1;
  localparam int L1   = (W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int L2   = (NW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int LD   = QW + 1;
  localparam int D1W  = 3 * W + 3 * VW + W;
  localparam int D2W  = 3 * W + DW;
  localparam int D3W  = 3 * W + 3 + 1;

  logic en;
  logic ready;

  assign en       = ready;
  assign in_stall = !ready;

  // Input register.
  logic    v0_r;
  ray_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
    end
  end

  coord_t s_in [3];
  coord_t e_in [3];
  coord_t p_in [3];

  assign s_in[0] = in_r.start_x;
  assign s_in[1] = in_r.start_y;
  assign s_in[2] = in_r.start_z;
  assign e_in[0] = in_r.end_x;
  assign e_in[1] = in_r.end_y;
  assign e_in[2] = in_r.end_z;
  assign p_in[0] = in_r.plane_a;
  assign p_in[1] = in_r.plane_b;
  assign p_in[2] = in_r.plane_c;

  // Stage 1: direction vector.
  logic                  v1_r;
  coord_t                s1_s_r [3];
  coord_t                s1_p_r [3];
  logic signed [VW-1:0]  s1_v_r [3];
  coord_t                s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dir
    always_ff @(posedge clk) begin
      if (en) begin
        s1_s_r[i] <= s_in[i];
        s1_p_r[i] <= p_in[i];
        s1_v_r[i] <= VW'(e_in[i]) - VW'(s_in[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r <= in_r.plane_offset;
    end
  end

  // Plane products against start point and direction.
  logic signed [SPW-1:0] ps [3];
  logic signed [DPW-1:0] pv [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul1
    rpi_mul #(.AW(W), .BW(W), .CHUNK(MUL_CHUNK)) u_mul_ps (
      .clk (clk),
      .en  (en),
      .a   (s1_p_r[i]),
      .b   (s1_s_r[i]),
      .p   (ps[i])
    );

    rpi_mul #(.AW(W), .BW(VW), .CHUNK(MUL_CHUNK)) u_mul_pv (
      .clk (clk),
      .en  (en),
      .a   (s1_p_r[i]),
      .b   (s1_v_r[i]),
      .p   (pv[i])
    );
  end

  logic           dl1_vld;
  logic [D1W-1:0] dl1_bits;

  rpi_delay #(.WIDTH(D1W), .DEPTH(L1)) u_dly1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v1_r),
    .in_bits  ({s1_s_r[0], s1_s_r[1], s1_s_r[2], s1_v_r[0], s1_v_r[1], s1_v_r[2], s1_d_r}),
    .out_vld  (dl1_vld),
    .out_bits (dl1_bits)
  );

  // Stage 2: plane sums at the start point and along the direction.
  logic                 v2_r;
  logic signed [NW-1:0] s2_n_r;
  logic signed [DW-1:0] s2_d_r;
  coord_t               s2_s_r [3];
  logic signed [VW-1:0] s2_v_r [3];
  coord_t               dl1_off;

  assign dl1_off = dl1_bits[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= dl1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n_r <= (NW'(dl1_off) <<< FRAC_BITS) + NW'(ps[0]) + NW'(ps[1]) + NW'(ps[2]);
      s2_d_r <= DW'(pv[0]) + DW'(pv[1]) + DW'(pv[2]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_st2
    always_ff @(posedge clk) begin
      if (en) begin
        s2_s_r[i] <= dl1_bits[D1W-1-i*W -: W];
        s2_v_r[i] <= dl1_bits[W+3*VW-1-i*VW -: VW];
      end
    end
  end

  // Numerators: plane sum at start times each direction component.
  logic signed [NUMW-1:0] num [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul2
    rpi_mul #(.AW(NW), .BW(VW), .CHUNK(MUL_CHUNK)) u_mul_num (
      .clk (clk),
      .en  (en),
      .a   (s2_n_r),
      .b   (s2_v_r[i]),
      .p   (num[i])
    );
  end

  logic           dl2_vld;
  logic [D2W-1:0] dl2_bits;

  rpi_delay #(.WIDTH(D2W), .DEPTH(L2)) u_dly2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v2_r),
    .in_bits  ({s2_s_r[0], s2_s_r[1], s2_s_r[2], s2_d_r}),
    .out_vld  (dl2_vld),
    .out_bits (dl2_bits)
  );

  // Stage 3: magnitudes for round-to-nearest division, ties away from zero.
  logic signed [DW-1:0] dl2_d;
  logic [DW-1:0]        abs_d;
  logic                 v3_r;
  logic [DAW-1:0]       s3_a_r [3];
  logic [DBW-1:0]       s3_b_r;
  logic                 s3_qneg_r [3];
  logic                 s3_dz_r;
  coord_t               s3_s_r [3];

  assign dl2_d = dl2_bits[DW-1:0];
  assign abs_d = dl2_d[DW-1] ? DW'(-dl2_d) : DW'(dl2_d);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= dl2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_b_r  <= DBW'(abs_d) << 1;
      s3_dz_r <= dl2_d == '0;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_st3
    logic [NUMW-1:0] abs_n;

    assign abs_n = num[i][NUMW-1] ? NUMW'(-num[i]) : NUMW'(num[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        s3_a_r[i]    <= (DAW'(abs_n) << 1) + DAW'(abs_d);
        s3_qneg_r[i] <= num[i][NUMW-1] == dl2_d[DW-1];
        s3_s_r[i]    <= dl2_bits[D2W-1-i*W -: W];
      end
    end
  end

  // Quotients, one divider per coordinate.
  logic [QW-1:0] quo [3];
  logic          ovf [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rpi_div #(.AW(DAW), .BW(DBW), .QW(QW)) u_div (
      .clk (clk),
      .en  (en),
      .num (s3_a_r[i]),
      .den (s3_b_r),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  logic           dl3_vld;
  logic [D3W-1:0] dl3_bits;

  rpi_delay #(.WIDTH(D3W), .DEPTH(LD)) u_dly3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3_r),
    .in_bits  ({s3_s_r[0], s3_s_r[1], s3_s_r[2],
                s3_qneg_r[0], s3_qneg_r[1], s3_qneg_r[2], s3_dz_r}),
    .out_vld  (dl3_vld),
    .out_bits (dl3_bits)
  );

  // Final stage: apply the quotient to the start point and saturate; a parallel line gives the origin.
  logic     fin_dz;
  coord_t   hit  [3];
  logic     sat  [3];
  hit_out_t fin_beat;

  assign fin_dz = dl3_bits[0];

  for (genvar i = 0; i < 3; i++) begin : g_fin
    logic                   qneg;
    coord_t                 s_val;
    logic signed [QW:0]     qmag;
    logic signed [QW:0]     qsgn;
    logic signed [QW+1:0]   r;
    logic                   sat_hi;
    logic                   sat_lo;

    assign qneg   = dl3_bits[3-i];
    assign s_val  = dl3_bits[D3W-1-i*W -: W];
    assign qmag   = {1'b0, quo[i]};
    assign qsgn   = qneg ? -qmag : qmag;
    assign r      = (QW+2)'(s_val) + (QW+2)'(qsgn);
    assign sat_hi = ovf[i] ? !qneg : (r > (QW+2)'(COORD_MAX));
    assign sat_lo = ovf[i] ? qneg : (r < (QW+2)'(COORD_MIN));
    assign sat[i] = sat_hi || sat_lo;

    always_comb begin
      if (fin_dz) begin
        hit[i] = '0;
      end else if (sat_hi) begin
        hit[i] = COORD_MAX;
      end else if (sat_lo) begin
        hit[i] = COORD_MIN;
      end else begin
        hit[i] = r[W-1:0];
      end
    end
  end

  always_comb begin
    fin_beat.hit_x = hit[0];
    fin_beat.hit_y = hit[1];
    fin_beat.hit_z = hit[2];
    if (fin_dz) begin
      fin_beat.status = STATUS_PARALLEL;
    end else if (sat[0] || sat[1] || sat[2]) begin
      fin_beat.status = STATUS_SAT;
    end else begin
      fin_beat.status = STATUS_OK;
    end
  end

  // Result queue.
  rpi_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (en && dl3_vld),
    .push_data (fin_beat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ready     (ready)
  );

endmodule
`default_nettype wire

>>> rtl/rpi_delay.sv
// Delay line that carries a valid bit and a side payload alongside a pipelined unit.
`default_nettype none
module rpi_delay import rpi_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [WIDTH-1:0] in_bits,
  output logic             out_vld,
  output logic [WIDTH-1:0] out_bits
);

  logic             vld_r  [0:DEPTH];
  logic [WIDTH-1:0] bits_r [0:DEPTH];

  assign vld_r[0]  = in_vld;
  assign bits_r[0] = in_bits;

  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    // Valid bits are control state and are cleared by reset.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bits_r[i+1] <= bits_r[i];
      end
    end
  end

  assign out_vld  = vld_r[DEPTH];
  assign out_bits = bits_r[DEPTH];

endmodule
`default_nettype wire

>>> rtl/rpi_mul.sv
// Pipelined signed multiplier that takes one slice of the first operand per stage.
`default_nettype none
module rpi_mul import rpi_pkg::*; #(
  parameter int AW    = 32,
  parameter int BW    = 32,
  parameter int CHUNK = MUL_CHUNK
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NCH = (AW + CHUNK - 1) / CHUNK;
  localparam int APW = NCH * CHUNK;
  localparam int PW  = AW + BW;

  logic signed [APW-1:0] a_r   [0:NCH];
  logic signed [BW-1:0]  b_r   [0:NCH];
  logic signed [PW-1:0]  acc_r [0:NCH];

  assign a_r[0]   = APW'(a);
  assign b_r[0]   = b;
  assign acc_r[0] = '0;

  for (genvar i = 0; i < NCH; i++) begin : g_stage
    logic signed [CHUNK:0]    slice;
    logic signed [CHUNK+BW:0] pp;
    logic signed [PW-1:0]     acc_nxt;

    // Lower slices are unsigned; the top slice carries the sign.
    if (i == NCH - 1) begin : g_top
      assign slice = {a_r[i][APW-1], a_r[i][i*CHUNK +: CHUNK]};
    end else begin : g_low
      assign slice = {1'b0, a_r[i][i*CHUNK +: CHUNK]};
    end

    assign pp      = slice * b_r[i];
    assign acc_nxt = acc_r[i] + (PW'(pp) <<< (i * CHUNK));

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i+1]   <= a_r[i];
        b_r[i+1]   <= b_r[i];
        acc_r[i+1] <= acc_nxt;
      end
    end
  end

  assign p = acc_r[NCH];

endmodule
`default_nettype wire

>>> rtl/rpi_div.sv
// Pipelined restoring divider with one quotient bit per stage and an overflow flag.
`default_nettype none
module rpi_div import rpi_pkg::*; #(
  parameter int AW = 64,
  parameter int BW = 32,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] num,
  input  logic [BW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int HW = AW - QW;
  localparam int CW = (HW > BW) ? HW : BW;

  logic [BW-1:0] rem_r [1:QW+1];
  logic [QW-1:0] low_r [1:QW+1];
  logic [QW-1:0] quo_r [1:QW+1];
  logic [BW-1:0] den_r [1:QW+1];
  logic          ovf_r [1:QW+1];

  logic [HW-1:0] hi;
  logic          ovf_in;

  // The quotient does not fit in QW bits when the upper part already reaches the divisor.
  assign hi     = num[AW-1:QW];
  assign ovf_in = CW'(hi) >= CW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[1] <= BW'(hi);
      low_r[1] <= num[QW-1:0];
      quo_r[1] <= '0;
      den_r[1] <= den;
      ovf_r[1] <= ovf_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [BW:0] trial;
    logic        ge;

    // Bring down the next dividend bit and subtract where the divisor fits.
    assign trial = {rem_r[k], low_r[k][QW-1]};
    assign ge    = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? BW'(trial - {1'b0, den_r[k]}) : BW'(trial);
        low_r[k+1] <= low_r[k] << 1;
        quo_r[k+1] <= {quo_r[k][QW-2:0], ge};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = quo_r[QW+1];
  assign ovf = ovf_r[QW+1];

endmodule
`default_nettype wire

>>> rtl/rpi_outq.sv
// Two-entry result queue with a registered ready that decouples the pipeline from the sink.
`default_nettype none
module rpi_outq import rpi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hit_out_t push_data,
  input  logic     out_stall,
  output logic     out_valid,
  output hit_out_t out_data,
  output logic     ready
);

  hit_out_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       ready_r, ready_nxt;
  logic       pop;

  assign pop = (count_r != 2'd0) && !out_stall;

  // Occupancy bookkeeping; ready drops once both entries are taken.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
    ready_nxt  = count_nxt < 2'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      ready_r  <= 1'b1;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      ready_r  <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = count_r != 2'd0;
  assign out_data  = mem_r[rd_ptr_r];
  assign ready     = ready_r;

endmodule
`default_nettype wire

>>> rtl/rpi_checker.sv
// Port-level checker for the intersection block and its bind to the top level.
`default_nettype none
`include "ray_plane_intersection_assert.svh"
module rpi_checker import rpi_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input hit_out_t out_data
);

  logic out_held;
  logic par_seen;
  logic sat_seen;
  logic hit_zero;
  logic at_limit;

  // Conditions on the result beat shown at the port.
  assign out_held = out_valid && out_stall;
  assign par_seen = out_valid && (out_data.status == STATUS_PARALLEL);
  assign sat_seen = out_valid && (out_data.status == STATUS_SAT);
  assign hit_zero = (out_data.hit_x == '0) && (out_data.hit_y == '0) && (out_data.hit_z == '0);
  assign at_limit = (out_data.hit_x == COORD_MAX) || (out_data.hit_x == COORD_MIN) ||
                    (out_data.hit_y == COORD_MAX) || (out_data.hit_y == COORD_MIN) ||
                    (out_data.hit_z == COORD_MAX) || (out_data.hit_z == COORD_MIN);

  // A stalled result beat stays on the port unchanged.
  `RPI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_data), "beat moved")

  // A parallel line reports the origin.
  `RPI_ASSERT_SAME(a_par_zero, clk, rst_n, par_seen, hit_zero, "parallel beat with nonzero point")

  // A saturated result has at least one coordinate at a limit.
  `RPI_ASSERT_SAME(a_sat_limit, clk, rst_n, sat_seen, at_limit, "saturated beat with no limit")

  // An empty result queue always has room in the next cycle.
  `RPI_ASSERT_NEXT(a_empty_ready, clk, rst_n, !out_valid, !in_stall, "stall after empty queue")

endmodule

bind ray_plane_intersection rpi_checker u_rpi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
